// File: rtl/core/bd_pkg.sv
// Shared types and codes for the bounded deque.
`default_nettype none

package bd_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_REAR   = 2'd2,
    ACT_POP_FRONT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 4;

  // controller -> datapath
  typedef struct packed {
    logic take;      // latch the input beat
    logic commit;    // apply the latched action to the ring
    logic load;      // load the result register
    logic from_mem;  // result carries the popped word from the read port
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_ok;    // latched action is a pop that will succeed
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/bd_if.sv
// Valid/ready channel interfaces for the deque's input and result beats.
`default_nettype none

interface bd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [31:0] data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface bd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] data_out;
  logic [3:0]  occupancy;

  modport source (output valid, output status, output data_out, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input data_out, input occupancy,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/bd_ctrl.sv
// Sequencing state machine for the deque: accept, execute, read, respond.
`default_nettype none

module bd_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire bd_pkg::sts_t sts,
  output bd_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.take     = in_valid && (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.pop_ok) begin
          // issue the read and move the pointers; the word lands next cycle
          cmd.commit = 1'b1;
          state_nxt  = S_READ;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          cmd.load   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.load     = 1'b1;
          cmd.from_mem = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bd_dp.sv
// Ring datapath for the deque: slot memory, head pointer, count, result register.
`default_nettype none

module bd_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bd_pkg::cmd_t       cmd,
  output bd_pkg::sts_t            sts,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [31:0] in_data_in,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_data_out,
  output logic [3:0]              out_occupancy
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

  logic [bd_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bd_pkg::WORD_W-1:0] rdata_r;

  bd_pkg::action_t           act_r;
  logic [bd_pkg::WORD_W-1:0] word_r;
  logic [AW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             count_r, count_nxt;

  logic [1:0]                res_status_r;
  logic [bd_pkg::WORD_W-1:0] res_data_r;
  logic [3:0]                res_occ_r;

  logic          is_pop, is_front, full, empty, refused;
  logic [CW-1:0] offset;
  logic [CW:0]   sum, wrapped;
  logic [AW-1:0] rear_pos, head_dec, head_inc;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          we, re;
  logic [CW+3:0] occ_wide;
  logic [1:0]    exec_status;

  assign is_pop   = (act_r == bd_pkg::ACT_POP_REAR) || (act_r == bd_pkg::ACT_POP_FRONT);
  assign is_front = (act_r == bd_pkg::ACT_PUSH_FRONT) || (act_r == bd_pkg::ACT_POP_FRONT);
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign refused  = is_pop ? empty : full;
  assign sts.pop_ok = is_pop && !empty;

  // rear slot: head + count for a push, head + count - 1 for a pop, mod DEPTH
  always_comb begin
    offset   = is_pop ? (count_r - CW'(1)) : count_r;
    sum      = (CW + 1)'(head_r) + (CW + 1)'(offset);
    wrapped  = (sum >= DEPTH_EXT) ? (sum - DEPTH_EXT) : sum;
    rear_pos = wrapped[AW-1:0];
    head_dec = (head_r == '0) ? LAST_IDX : (head_r - AW'(1));
    head_inc = (head_r == LAST_IDX) ? '0 : (head_r + AW'(1));
  end

  always_comb begin
    head_nxt = head_r;
    count_nxt = count_r;
    wr_addr  = rear_pos;
    rd_addr  = rear_pos;
    we       = 1'b0;
    re       = 1'b0;
    if (cmd.commit && !refused) begin
      case (act_r)
        bd_pkg::ACT_PUSH_REAR: begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        bd_pkg::ACT_PUSH_FRONT: begin
          we        = 1'b1;
          wr_addr   = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
        bd_pkg::ACT_POP_REAR: begin
          re        = 1'b1;
          count_nxt = count_r - CW'(1);
        end
        bd_pkg::ACT_POP_FRONT: begin
          re        = 1'b1;
          rd_addr   = head_r;
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // occupancy field is four bits wide; keep its low bits
  assign occ_wide = (CW + 4)'(count_nxt);

  always_comb begin
    exec_status = bd_pkg::ST_OK;
    if (refused) begin
      exec_status = is_front ? (is_pop ? bd_pkg::ST_EMPTY : bd_pkg::ST_FULL)
                             : (is_pop ? bd_pkg::ST_EMPTY : bd_pkg::ST_FULL);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= word_r;
    end
    if (re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r  <= bd_pkg::action_t'(in_action);
      word_r <= in_data_in;
    end
    if (cmd.load) begin
      if (cmd.from_mem) begin
        res_status_r <= bd_pkg::ST_OK;
        res_data_r   <= rdata_r;
      end else begin
        res_status_r <= exec_status;
        res_data_r   <= '0;
      end
      res_occ_r <= occ_wide[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_status    = res_status_r;
  assign out_data_out  = res_data_r;
  assign out_occupancy = res_occ_r;

endmodule

`default_nettype wire

// File: rtl/core/bounded_deque.sv
// Top level of the bounded deque: controller and ring datapath on two channels.
//
// Fixed-capacity double-ended queue of signed 32-bit words held in a ring of
// DEPTH slots with a head pointer and a fill count. Each input beat on in_ch
// carries an action (push rear, push front, pop rear, pop front) and a word;
// each accepted beat yields exactly one result beat on out_ch with a status
// (ok, full, empty), the popped word (zero otherwise) and the low four bits
// of the occupancy after the action.
// Timing: a push or a refused action is latched when the input beat is
// accepted and its result is loaded in the execute step; a successful pop
// first reads its slot through the memory's registered read port and is
// loaded in the read step. One item is in flight at a time, so the block
// does not take a new input beat before the previous item is loaded.
// The next input beat is taken as soon as the previous item has been loaded
// into the result register, even while that result is still waiting; if the
// receiver stalls, the new item holds in execute (a successful pop reads its
// slot first and holds in the read step) until the result register frees up,
// and in_ch.ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the deque and drops any pending
// result; slot contents are not cleared and are only read after a push.
`default_nettype none

module bounded_deque #(
  parameter int unsigned DEPTH = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  bd_in_if.sink    in_ch,
  bd_out_if.source out_ch
);

  bd_pkg::cmd_t cmd;
  bd_pkg::sts_t sts;

  // sequencing: hand off beats, gate the result register on the receiver
  bd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring storage, pointers and result payload
  bd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_data_in    (in_ch.data_in),
    .out_status    (out_ch.status),
    .out_data_out  (out_ch.data_out),
    .out_occupancy (out_ch.occupancy)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the bounded deque: scoreboard class plus stimulus tasks.
`default_nettype none

// Track the deque contents alongside the block and hold the expected result beats.
class deque_scoreboard;
  localparam int unsigned CAP = 8;

  typedef struct {
    bd_pkg::status_t status;
    logic [31:0]     word;
    logic [3:0]      occ;
  } deque_result_t;

  logic [31:0]   ring_words [CAP];
  int unsigned   front_pos;
  int unsigned   word_count;
  deque_result_t awaited_q [$];
  int unsigned   mismatches;

  function new();
    front_pos  = 0;
    word_count = 0;
    mismatches = 0;
    foreach (ring_words[i]) ring_words[i] = '0;
  endfunction

  // Apply one accepted action to the shadow ring and queue its result.
  function void note_beat(bd_pkg::action_t act, logic [31:0] word);
    deque_result_t res;
    res.status = bd_pkg::ST_OK;
    res.word   = '0;
    case (act)
      bd_pkg::ACT_PUSH_REAR, bd_pkg::ACT_PUSH_FRONT: begin
        if (word_count >= CAP) begin
          res.status = bd_pkg::ST_FULL;
        end else if (act == bd_pkg::ACT_PUSH_REAR) begin
          ring_words[(front_pos + word_count) % CAP] = word;
          word_count++;
        end else begin
          front_pos = (front_pos + CAP - 1) % CAP;
          ring_words[front_pos] = word;
          word_count++;
        end
      end
      default: begin
        if (word_count == 0) begin
          res.status = bd_pkg::ST_EMPTY;
        end else if (act == bd_pkg::ACT_POP_REAR) begin
          res.word = ring_words[(front_pos + word_count - 1) % CAP];
          word_count--;
        end else begin
          res.word  = ring_words[front_pos];
          front_pos = (front_pos + 1) % CAP;
          word_count--;
        end
      end
    endcase
    res.occ = word_count[3:0];
    awaited_q.push_back(res);
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", what);
  endfunction

  // Compare one result beat against the oldest expectation.
  function void check_beat(logic [1:0] status, logic [31:0] word, logic [3:0] occ);
    deque_result_t res;
    if (awaited_q.size() == 0) begin
      report($sformatf("unexpected result status=%0d word=%h occ=%0d", status, word, occ));
      return;
    end
    res = awaited_q.pop_front();
    if (status !== res.status || word !== res.word || occ !== res.occ)
      report($sformatf("status %0d/%0d word %h/%h occ %0d/%0d (expected/actual)",
                       res.status, status, res.word, word, res.occ, occ));
  endfunction

  function int unsigned pending();
    return awaited_q.size();
  endfunction
endclass

module tb;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int unsigned LONG_HOLD    = 120;   // receiver hold-off length
  localparam int unsigned HOLD_AT      = 400;   // input beats before the hold-off

  logic clk;
  logic rst_n;

  bd_in_if  in_ch ();
  bd_out_if out_ch ();

  bounded_deque #(.DEPTH(8)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  deque_scoreboard deque_sb = new();

  int unsigned beats_in;
  int unsigned quiet_cycles;
  bit          hold_gaps;     // set while the receiver holds off; sender keeps offering
  int unsigned burst_left;
  int unsigned push_pct;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Monitor: note accepted input beats, check accepted result beats and
  // run the watchdog. Everything is sampled at the rising edge, before the
  // block's own updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        deque_sb.note_beat(bd_pkg::action_t'(in_ch.action), in_ch.data_in);
        beats_in++;
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        deque_sb.check_beat(out_ch.status, out_ch.data_out, out_ch.occupancy);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("bounded_deque test failed");
        $finish;
      end
    end
  end

  // Receiver: alternate runs of ready with short stalls, sometimes a long
  // stall-free stretch, and once a long hold-off so the block backs up and
  // drops in_ch.ready while the sender keeps offering.
  initial begin : receiver
    int unsigned run_len;
    int unsigned stall_len;
    bit          held;
    out_ch.ready = 1'b0;
    hold_gaps    = 1'b0;
    held         = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held && beats_in >= HOLD_AT) begin
        held         = 1'b1;
        hold_gaps    = 1'b1;
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_gaps = 1'b0;
      end
      run_len   = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12);
      stall_len = $urandom_range(0, 6);
      out_ch.ready = 1'b1;
      repeat (run_len) @(negedge clk);
      if (stall_len != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  // Offer one beat from a falling edge and hold it until it is taken.
  // Return at a falling edge with valid still high.
  task automatic offer_beat(input bd_pkg::action_t act, input logic [31:0] word);
    in_ch.valid   = 1'b1;
    in_ch.action  = act;
    in_ch.data_in = word;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait out the result beats still owed.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (deque_sb.pending() != 0) @(negedge clk);
  endtask

  // Random beat with burst/gap pacing on the sender side.
  task automatic paced_beat(input bd_pkg::action_t act, input logic [31:0] word);
    if (burst_left == 0) begin
      if (!hold_gaps) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 25);
    end
    burst_left--;
    offer_beat(act, word);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bd_pkg::action_t pick_action();
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? bd_pkg::ACT_PUSH_FRONT : bd_pkg::ACT_PUSH_REAR;
    return $urandom_range(0, 1) ? bd_pkg::ACT_POP_FRONT : bd_pkg::ACT_POP_REAR;
  endfunction

  initial begin : stimulus
    in_ch.valid   = 1'b0;
    in_ch.action  = bd_pkg::ACT_PUSH_REAR;
    in_ch.data_in = '0;
    beats_in      = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    push_pct      = 50;
    rst_n         = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Pops on an empty deque, then the extreme words through both ends.
    offer_beat(bd_pkg::ACT_POP_REAR, 32'h1234_5678);
    offer_beat(bd_pkg::ACT_POP_FRONT, 32'hffff_ffff);
    offer_beat(bd_pkg::ACT_PUSH_REAR, 32'h7fff_ffff);
    offer_beat(bd_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
    offer_beat(bd_pkg::ACT_POP_REAR, 32'h0);
    offer_beat(bd_pkg::ACT_POP_FRONT, 32'h0);
    offer_beat(bd_pkg::ACT_POP_FRONT, 32'h0);
    // Fill from the front first so the head wraps backwards around the ring.
    offer_beat(bd_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
    offer_beat(bd_pkg::ACT_PUSH_FRONT, 32'hffff_ffff);
    offer_beat(bd_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
    offer_beat(bd_pkg::ACT_PUSH_FRONT, 32'haaaa_aaaa);
    offer_beat(bd_pkg::ACT_PUSH_REAR, 32'h0000_0001);
    offer_beat(bd_pkg::ACT_PUSH_REAR, 32'h8000_0001);
    offer_beat(bd_pkg::ACT_PUSH_REAR, 32'h7fff_fffe);
    offer_beat(bd_pkg::ACT_PUSH_REAR, 32'hdead_beef);
    // Full: both pushes are refused and leave the contents alone.
    offer_beat(bd_pkg::ACT_PUSH_REAR, 32'h0bad_0bad);
    offer_beat(bd_pkg::ACT_PUSH_FRONT, 32'h0bad_0bad);
    // Empty it from both ends, then one more pop past empty.
    repeat (4) offer_beat(bd_pkg::ACT_POP_REAR, 32'h0);
    repeat (4) offer_beat(bd_pkg::ACT_POP_FRONT, 32'h0);
    offer_beat(bd_pkg::ACT_POP_REAR, 32'h0);
    drain_results();

    // Random part: shift the push/pop mix every few dozen beats so the
    // deque keeps sweeping between empty and full.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 80;
          1:       push_pct = 20;
          2:       push_pct = 65;
          default: push_pct = 50;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      paced_beat(pick_action(), pick_word());
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (deque_sb.mismatches == 0 && deque_sb.pending() == 0) begin
      $display("bounded_deque test passed");
    end else begin
      $display("bounded_deque test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
